// ----- src/macc_pkg.sv -----
// Shared constants, types and helper functions of the moving average crossover counter.
package macc_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 16;
  localparam int ADDR_W    = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_W    = SUM_W + CNT_W + 1;
  localparam int CLAMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_WINDOW  = 1'b0,
    REG_SECOND_WINDOW = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] FIRST_WINDOW_RESET  = CFG_W'(4);
  localparam logic [CFG_W-1:0] SECOND_WINDOW_RESET = CFG_W'(16);

  // A zero window acts as one, and anything above the history depth as the depth.
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] reg_val);
    logic [CLAMP_W-1:0] v;
    v = CLAMP_W'(reg_val);
    if (v == '0) begin
      return CNT_W'(1);
    end
    if (v > CLAMP_W'(MAX_WINDOW)) begin
      return CNT_W'(MAX_WINDOW);
    end
    return CNT_W'(v);
  endfunction

endpackage

// ----- src/macc_ram.sv -----
// Generic dual read port RAM with one write port and registered read data.
module macc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- src/moving_average_crossover_counter_core.sv -----
// Top level of the moving average crossover counter: sample pipeline, trend and crossing count.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   input   | in        | in_valid, in_stall, in_sample, in_start_series
//   result  | out       | out_valid, out_stall, out_crossings, out_trend,
//           |           | out_trend_valid
//   config  | in        | cfg_wr_en, cfg_index, cfg_data
//
// One sample per cycle unless the output stalls; results go through stages one, two and three.
// The history RAM holds running series totals, so a window sum is one RAM read and one
// subtraction whatever the window length; the RAM read register sets the first stage.
// Reset clears the pipeline, the series state and the window registers to 4 and 16.
// A stalled result holds the pipeline back one stage at a time, so bubbles are filled.
module moving_average_crossover_counter_core
  import macc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_series,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COUNT_W-1:0]            out_crossings,
  output logic                          out_trend,
  output logic                          out_trend_valid,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  function automatic logic [ADDR_W-1:0] back_addr(input logic [ADDR_W-1:0] wp,
                                                  input logic [CNT_W-1:0]  w);
    logic [ADDR_W:0] a;
    logic [ADDR_W:0] wx;
    a  = {1'b0, wp};
    wx = (ADDR_W + 1)'(w);
    if (a >= wx) begin
      return ADDR_W'(a - wx);
    end
    return ADDR_W'(a + (ADDR_W + 1)'(MAX_WINDOW) - wx);
  endfunction

  logic [CFG_W-1:0] first_window_r, second_window_r;

  logic [ADDR_W-1:0]       wp_r, wp_base, wp_nxt;
  logic [CNT_W-1:0]        seen_r, seen_base, seen_nxt;
  logic signed [SUM_W-1:0] total_r, total_base, total_nxt;
  logic [CNT_W-1:0]        w1, w2, longest;
  logic [ADDR_W-1:0]       addr_a, addr_b;

  logic                    s1_valid_r, s1_sub1_r, s1_sub2_r, s1_tv_r, s1_start_r;
  logic signed [SUM_W-1:0] s1_total_r;
  logic [CNT_W-1:0]        s1_w1_r, s1_w2_r;
  logic signed [SUM_W-1:0] hist_a, hist_b, sum1, sum2;
  logic signed [PROD_W-1:0] lhs_nxt, rhs_nxt;

  logic                     s2_valid_r, s2_tv_r, s2_start_r;
  logic signed [PROD_W-1:0] s2_lhs_r, s2_rhs_r;

  logic               out_valid_r, out_trend_r, out_tv_r;
  logic [COUNT_W-1:0] count_r, count_base, count_nxt;
  logic               prev_r, held_r, prev_base, held_base, prev_nxt, held_nxt, trend_nxt;

  logic rdy_out, rdy_s2, rdy_s1, in_accept;

  assign rdy_out   = !out_valid_r || !out_stall;
  assign rdy_s2    = !s2_valid_r || rdy_out;
  assign rdy_s1    = !s1_valid_r || rdy_s2;
  assign in_stall  = !rdy_s1;
  assign in_accept = in_valid && rdy_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_window_r  <= FIRST_WINDOW_RESET;
      second_window_r <= SECOND_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIRST_WINDOW:  first_window_r  <= cfg_data;
        REG_SECOND_WINDOW: second_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one: series bookkeeping and history access.
  always_comb begin
    w1         = eff_window(first_window_r);
    w2         = eff_window(second_window_r);
    longest    = (w1 > w2) ? w1 : w2;
    wp_base    = in_start_series ? '0 : wp_r;
    seen_base  = in_start_series ? '0 : seen_r;
    total_base = in_start_series ? '0 : total_r;
    total_nxt  = total_base + SUM_W'(in_sample);
    wp_nxt     = (wp_base == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_base + 1'b1;
    seen_nxt   = (seen_base == CNT_W'(MAX_WINDOW + 1)) ? seen_base : seen_base + 1'b1;
    addr_a     = back_addr(wp_base, w1);
    addr_b     = back_addr(wp_base, w2);
  end

  macc_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk       (clk),
    .wr_en     (in_accept),
    .wr_addr   (wp_base),
    .wr_data   (total_nxt),
    .rd_en     (in_accept),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (hist_a),
    .rd_data_b (hist_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      seen_r     <= '0;
      total_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (rdy_s1) begin
        s1_valid_r <= in_accept;
      end
      if (in_accept) begin
        wp_r    <= wp_nxt;
        seen_r  <= seen_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_total_r <= total_nxt;
      s1_sub1_r  <= seen_nxt > w1;
      s1_sub2_r  <= seen_nxt > w2;
      s1_tv_r    <= seen_nxt >= longest;
      s1_start_r <= in_start_series;
      s1_w1_r    <= w1;
      s1_w2_r    <= w2;
    end
  end

  // Stage two: window sums and the cross-multiplied averages.
  always_comb begin
    sum1    = s1_total_r - (s1_sub1_r ? hist_a : SUM_W'(0));
    sum2    = s1_total_r - (s1_sub2_r ? hist_b : SUM_W'(0));
    lhs_nxt = sum1 * $signed({1'b0, s1_w2_r});
    rhs_nxt = sum2 * $signed({1'b0, s1_w1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s2 && s1_valid_r) begin
      s2_lhs_r   <= lhs_nxt;
      s2_rhs_r   <= rhs_nxt;
      s2_tv_r    <= s1_tv_r;
      s2_start_r <= s1_start_r;
    end
  end

  // Stage three: trend decision and the saturating crossing count.
  always_comb begin
    count_base = s2_start_r ? '0 : count_r;
    prev_base  = s2_start_r ? 1'b0 : prev_r;
    held_base  = s2_start_r ? 1'b0 : held_r;
    trend_nxt  = s2_tv_r && !(s2_lhs_r < s2_rhs_r);
    count_nxt  = count_base;
    prev_nxt   = prev_base;
    held_nxt   = held_base;
    if (s2_tv_r) begin
      if (held_base && (trend_nxt != prev_base) && (count_base != '1)) begin
        count_nxt = count_base + 1'b1;
      end
      prev_nxt = trend_nxt;
      held_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      prev_r      <= 1'b0;
      held_r      <= 1'b0;
    end else begin
      if (rdy_out) begin
        out_valid_r <= s2_valid_r;
      end
      if (rdy_out && s2_valid_r) begin
        count_r <= count_nxt;
        prev_r  <= prev_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && s2_valid_r) begin
      out_trend_r <= trend_nxt;
      out_tv_r    <= s2_tv_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_crossings   = count_r;
  assign out_trend       = out_trend_r;
  assign out_trend_valid = out_tv_r;

endmodule

// ----- tb/crossover_checker.sv -----
// Checker for the moving average crossover counter: predicts every result and compares it.
module crossover_checker
  import macc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_series,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [COUNT_W-1:0]            out_crossings,
  input  logic                          out_trend,
  input  logic                          out_trend_valid,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            results_seen,
  output int                            valid_trends,
  output logic [COUNT_W-1:0]            peak_crossings
);

  typedef struct packed {
    logic [COUNT_W-1:0] crossings;
    logic               trend;
    logic               trend_valid;
  } trend_result_t;

  trend_result_t                 pending_trends[$];
  logic signed [SAMPLE_BITS-1:0] history[MAX_WINDOW];
  int unsigned                   head;
  int unsigned                   filled;
  logic [COUNT_W-1:0]            crossing_count;
  logic                          last_trend;
  logic                          trend_known;
  logic [CFG_W-1:0]              first_len_reg;
  logic [CFG_W-1:0]              second_len_reg;
  int                            err_count;
  int                            checked;
  int                            valid_count;
  logic [COUNT_W-1:0]            peak;

  assign mismatches     = err_count;
  assign results_seen   = checked;
  assign valid_trends   = valid_count;
  assign peak_crossings = peak;

  initial begin
    err_count   = 0;
    checked     = 0;
    valid_count = 0;
    peak        = '0;
    pending     = 0;
    foreach (history[i]) history[i] = '0;
  end

  function automatic int unsigned window_len(logic [CFG_W-1:0] r);
    if (r == '0) begin
      return 1;
    end
    if (r > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return r;
  endfunction

  function automatic longint window_total(int unsigned len);
    int unsigned n;
    int unsigned idx;
    longint      acc;
    n   = (len < filled) ? len : filled;
    acc = 0;
    for (int unsigned k = 0; k < n; k++) begin
      idx = (head + MAX_WINDOW - 1 - k) % MAX_WINDOW;
      acc += longint'(history[idx]);
    end
    return acc;
  endfunction

  task automatic report(string msg);
    if (err_count < 200) begin
      $display("MISMATCH at result %0d: %s", checked, msg);
    end
    err_count++;
  endtask

  task automatic advance_series(logic signed [SAMPLE_BITS-1:0] s, logic fresh);
    int unsigned   w1;
    int unsigned   w2;
    longint        lhs;
    longint        rhs;
    trend_result_t r;
    w1 = window_len(first_len_reg);
    w2 = window_len(second_len_reg);
    if (fresh) begin
      head           = 0;
      filled         = 0;
      crossing_count = '0;
      last_trend     = 1'b0;
      trend_known    = 1'b0;
    end
    history[head] = s;
    head          = (head + 1) % MAX_WINDOW;
    if (filled < MAX_WINDOW) begin
      filled++;
    end
    r = '0;
    if (filled >= ((w1 > w2) ? w1 : w2)) begin
      // Cross-multiplying the sums compares the averages without a division.
      lhs     = window_total(w1) * longint'(w2);
      rhs     = window_total(w2) * longint'(w1);
      r.trend = (lhs < rhs) ? 1'b0 : 1'b1;
      if (trend_known && r.trend != last_trend && crossing_count != '1) begin
        crossing_count++;
      end
      last_trend    = r.trend;
      trend_known   = 1'b1;
      r.trend_valid = 1'b1;
    end
    r.crossings = crossing_count;
    pending_trends.push_back(r);
  endtask

  task automatic check_result();
    trend_result_t want;
    if (pending_trends.size() == 0) begin
      report($sformatf("result with nothing expected (crossings %0d, trend %0b, valid %0b)",
                       out_crossings, out_trend, out_trend_valid));
      return;
    end
    want = pending_trends.pop_front();
    if (out_crossings !== want.crossings) begin
      report($sformatf("crossings %0d, expected %0d", out_crossings, want.crossings));
    end
    if (out_trend !== want.trend) begin
      report($sformatf("trend %0b, expected %0b", out_trend, want.trend));
    end
    if (out_trend_valid !== want.trend_valid) begin
      report($sformatf("trend_valid %0b, expected %0b", out_trend_valid, want.trend_valid));
    end
    if (want.trend_valid) begin
      valid_count++;
    end
    if (want.crossings > peak) begin
      peak = want.crossings;
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head           = 0;
      filled         = 0;
      crossing_count = '0;
      last_trend     = 1'b0;
      trend_known    = 1'b0;
      first_len_reg  = FIRST_WINDOW_RESET;
      second_len_reg = SECOND_WINDOW_RESET;
      pending_trends.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FIRST_WINDOW: begin
            first_len_reg = cfg_data;
          end
          REG_SECOND_WINDOW: begin
            second_len_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_series(in_sample, in_start_series);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
      pending <= pending_trends.size();
    end
  end

endmodule

// ----- tb/moving_average_crossover_counter_core_tb.sv -----
// Testbench top for the moving average crossover counter: clock, reset, stimulus and verdict.
module moving_average_crossover_counter_core_tb;
  import macc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FLIP_ITEMS  = 120;

  typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_SWING, SHAPE_FLAT} shape_t;

  logic                          clk;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample       = '0;
  logic                          in_start_series = 1'b0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [COUNT_W-1:0]            out_crossings;
  logic                          out_trend;
  logic                          out_trend_valid;
  logic                          cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index       = REG_FIRST_WINDOW;
  logic [CFG_W-1:0]              cfg_data        = '0;

  int                 mismatches;
  int                 pending;
  int                 results_seen;
  int                 valid_trends;
  logic [COUNT_W-1:0] peak_crossings;

  bit tx_gaps   = 1'b1;
  bit rx_gaps   = 1'b1;
  bit long_hold = 1'b0;
  int cycle_count = 0;
  int items_sent  = 0;
  int series_count = 0;
  int settings_count = 1;

  logic [CFG_W-1:0] first_set[8]  = '{7'd1, 7'd0,   7'd64, 7'd1,  7'd127, 7'd65, 7'd0, 7'd0};
  logic [CFG_W-1:0] second_set[8] = '{7'd1, 7'd127, 7'd1,  7'd64, 7'd0,   7'd65, 7'd0, 7'd0};

  moving_average_crossover_counter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_start_series (in_start_series),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_crossings   (out_crossings),
    .out_trend       (out_trend),
    .out_trend_valid (out_trend_valid),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  crossover_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_start_series (in_start_series),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_crossings   (out_crossings),
    .out_trend       (out_trend),
    .out_trend_valid (out_trend_valid),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_seen    (results_seen),
    .valid_trends    (valid_trends),
    .peak_crossings  (peak_crossings)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("** moving_average_crossover_counter_core: FAILED **");
      $finish;
    end
  end

  // Result side: a random hold-off before each transfer while rx_gaps is set, or a long one when asked for.
  initial begin
    int gap;
    forever begin
      gap = rx_gaps ? $urandom_range(0, 5) : 0;
      if (long_hold) begin
        gap       = 60;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send(logic signed [SAMPLE_BITS-1:0] s, logic fresh);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_start_series <= fresh;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (fresh) begin
      series_count++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_windows(logic [CFG_W-1:0] first_len, logic [CFG_W-1:0] second_len);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FIRST_WINDOW;
    cfg_data  <= first_len;
    @(posedge clk);
    cfg_index <= REG_SECOND_WINDOW;
    cfg_data  <= second_len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  task automatic feed_series(int len, shape_t shape, logic fresh);
    int   level;
    int   v;
    logic st;
    level = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      st = (i == 0) ? fresh : ($urandom_range(0, 59) == 0);
      case (shape)
        SHAPE_NOISE: begin
          v = int'($urandom_range(0, 65535)) - 32768;
        end
        SHAPE_WALK: begin
          level = level + int'($urandom_range(0, 6000)) - 3000;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
          v = level;
        end
        SHAPE_SWING: begin
          v = (i % 2 == 0) ? 32767 - int'($urandom_range(0, 3))
                           : -32768 + int'($urandom_range(0, 3));
        end
        default: begin
          v = level;
        end
      endcase
      send(SAMPLE_BITS'(v), st);
    end
  endtask

  // Each phase opens with a burst against a long result hold-off, then mixes random series.
  task automatic run_phase(int target);
    int done;
    int len;
    long_hold = 1'b1;
    tx_gaps   = 1'b0;
    feed_series(40, SHAPE_WALK, 1'($urandom_range(0, 1)));
    done = 40;
    while (done < target) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 140);
      feed_series(len, shape_t'($urandom_range(0, 3)), 1'b1);
      done += len;
    end
    settle();
  endtask

  initial begin
    first_set[6]  = CFG_W'($urandom_range(0, 127));
    second_set[6] = CFG_W'($urandom_range(0, 127));
    first_set[7]  = CFG_W'($urandom_range(2, 20));
    second_set[7] = CFG_W'($urandom_range(2, 20));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset windows: extremes of the sample range, the fill-up and a restart mid-series.
    send(16'sh7fff, 1'b1);
    repeat (15) send(16'sh8000, 1'b0);
    repeat (3) send(16'sh7fff, 1'b0);
    send(16'sh0000, 1'b1);
    send(-16'sd1, 1'b0);
    send(16'sd1, 1'b0);
    settle();
    run_phase(150);

    foreach (first_set[i]) begin
      set_windows(first_set[i], second_set[i]);
      run_phase(150);
    end

    // Windows of one and two with an alternating series flip the trend on every sample.
    set_windows(7'd1, 7'd2);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < FLIP_ITEMS; i++) begin
      send((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 0);
    end
    settle();

    $display("Run covered %0d samples in %0d series under %0d window settings.",
             items_sent, series_count, settings_count);
    $display("%0d results checked, %0d with a valid trend; highest crossing count %0d.",
             results_seen, valid_trends, peak_crossings);
    if (mismatches == 0) begin
      $display("** moving_average_crossover_counter_core: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** moving_average_crossover_counter_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- moving_average_crossover_counter_core.f -----
src/macc_pkg.sv
src/macc_ram.sv
src/moving_average_crossover_counter_core.sv
tb/crossover_checker.sv
tb/moving_average_crossover_counter_core_tb.sv
